[src/bbc_pkg.sv]
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int unsigned StackDepthDefault = 128;

  localparam int unsigned ChW       = 8;
  localparam int unsigned VerdictW  = 3;
  localparam int unsigned OpenLeftW = 8;
  localparam int unsigned KindW     = 2;

  localparam logic [ChW-1:0] ChOpenRound  = 8'h28;
  localparam logic [ChW-1:0] ChOpenCurly  = 8'h7B;
  localparam logic [ChW-1:0] ChOpenSquare = 8'h5B;
  localparam logic [ChW-1:0] ChCloseRound  = 8'h29;
  localparam logic [ChW-1:0] ChCloseCurly  = 8'h7D;
  localparam logic [ChW-1:0] ChCloseSquare = 8'h5D;

  localparam logic [KindW-1:0] KindRound  = 2'd0;
  localparam logic [KindW-1:0] KindCurly  = 2'd1;
  localparam logic [KindW-1:0] KindSquare = 2'd2;
  localparam logic [KindW-1:0] KindNone   = 2'd3;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_OK              = 3'd0,
    VERDICT_UNMATCHED_CLOSE = 3'd1,
    VERDICT_MISMATCH        = 3'd2,
    VERDICT_UNCLOSED        = 3'd3,
    VERDICT_OVERFLOW        = 3'd4
  } verdict_e;

  function automatic logic [KindW-1:0] open_kind(input logic [ChW-1:0] ch);
    logic [KindW-1:0] k;
    case (ch)
      ChOpenRound:  k = KindRound;
      ChOpenCurly:  k = KindCurly;
      ChOpenSquare: k = KindSquare;
      default:      k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [KindW-1:0] close_kind(input logic [ChW-1:0] ch);
    logic [KindW-1:0] k;
    case (ch)
      ChCloseRound:  k = KindRound;
      ChCloseCurly:  k = KindCurly;
      ChCloseSquare: k = KindSquare;
      default:       k = KindNone;
    endcase
    return k;
  endfunction

endpackage

[src/bbc_if.sv]
`timescale 1ns / 1ps

interface bbc_in_if;
  logic                     valid;
  logic                     ready;
  logic [bbc_pkg::ChW-1:0]  ch;
  logic                     is_last;

  modport source (output valid, output ch, output is_last, input ready);
  modport sink (input valid, input ch, input is_last, output ready);
endinterface

interface bbc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          balanced;
  logic [bbc_pkg::VerdictW-1:0]  verdict;
  logic [bbc_pkg::OpenLeftW-1:0] open_left;

  modport source (output valid, output balanced, output verdict, output open_left, input ready);
  modport sink (input valid, input balanced, input verdict, input open_left, output ready);
endinterface

[src/bracket_balance_checker_core.sv]
`timescale 1ns / 1ps

// Bracket balance checker. Characters of an expression arrive on in_i, one per
// transfer, and the final character carries is_last. Opening brackets are kept
// on a stack in a synchronous memory of STACK_DEPTH entries, with the top entry
// cached in a register so that a push or a pop completes every cycle.
// Throughput is one character per cycle while in_i.ready is high. A pop
// re-reads the new top from the memory port, and the read data is used
// directly in the following cycle. For each expression one verdict transfer
// leaves on out_o once the final character is taken. It carries balanced, the
// verdict code and the number of openings still pending, saturated at 255.
// The output register is backed by a skid register, so input transfers go on
// while a verdict waits; in_i.ready drops only when both hold a verdict.
// Reset clears the stack depth, the error state and the valid flags of both
// output registers; the stack memory itself is not cleared and needs no
// clearing pass. Each final character clears the depth and error state again.
module bracket_balance_checker_core #(
  parameter int unsigned STACK_DEPTH = bbc_pkg::StackDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbc_in_if.sink        in_i,
  bbc_out_if.source     out_o
);

  localparam int unsigned DepthW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned SatW   = (DepthW > bbc_pkg::OpenLeftW) ? DepthW : bbc_pkg::OpenLeftW;

  typedef struct packed {
    logic                          balanced;
    logic [bbc_pkg::VerdictW-1:0]  verdict;
    logic [bbc_pkg::OpenLeftW-1:0] open_left;
  } result_t;

  logic [bbc_pkg::KindW-1:0] mem_q [STACK_DEPTH];
  logic [bbc_pkg::KindW-1:0] rd_data_q;

  logic [DepthW-1:0]         depth_q, depth_d;
  bbc_pkg::verdict_e         err_q, err_d;
  logic [bbc_pkg::KindW-1:0] top_q, top_d;
  logic                      sel_mem_q;

  logic                      out_valid_q, skid_valid_q;
  result_t                   out_data_q, skid_data_q;

  logic                      acc, last_acc, no_err, full, empty;
  logic                      is_open, is_close, push, pop, rd_en;
  logic [bbc_pkg::KindW-1:0] open_k, close_k, top_eff;
  logic [AddrW-1:0]          wr_addr, rd_addr;
  logic [SatW-1:0]           depth_ext;
  bbc_pkg::verdict_e         verdict;
  result_t                   res;

  assign in_i.ready = !skid_valid_q;
  assign acc        = in_i.valid && in_i.ready;
  assign last_acc   = acc && in_i.is_last;

  assign open_k   = bbc_pkg::open_kind(in_i.ch);
  assign close_k  = bbc_pkg::close_kind(in_i.ch);
  assign is_open  = open_k != bbc_pkg::KindNone;
  assign is_close = close_k != bbc_pkg::KindNone;
  assign no_err   = err_q == bbc_pkg::VERDICT_OK;
  assign full     = depth_q == DepthW'(STACK_DEPTH);
  assign empty    = depth_q == '0;
  assign top_eff  = sel_mem_q ? rd_data_q : top_q;

  assign push = acc && no_err && is_open && !full;
  assign pop  = acc && no_err && is_close && !empty && (top_eff == close_k);

  assign wr_addr = depth_q[AddrW-1:0];
  assign rd_addr = AddrW'(depth_q - DepthW'(2));
  assign rd_en   = pop && (depth_q >= DepthW'(2));

  always_comb begin
    err_d = err_q;
    if (acc && no_err) begin
      if (is_open && full) begin
        err_d = bbc_pkg::VERDICT_OVERFLOW;
      end else if (is_close && empty) begin
        err_d = bbc_pkg::VERDICT_UNMATCHED_CLOSE;
      end else if (is_close && (top_eff != close_k)) begin
        err_d = bbc_pkg::VERDICT_MISMATCH;
      end
    end
  end

  always_comb begin
    depth_d = depth_q;
    if (push) begin
      depth_d = depth_q + DepthW'(1);
    end else if (pop) begin
      depth_d = depth_q - DepthW'(1);
    end
  end

  assign top_d = push ? open_k : top_eff;

  always_comb begin
    if (err_d != bbc_pkg::VERDICT_OK) begin
      verdict = err_d;
    end else if (depth_d != '0) begin
      verdict = bbc_pkg::VERDICT_UNCLOSED;
    end else begin
      verdict = bbc_pkg::VERDICT_OK;
    end
  end

  assign depth_ext     = SatW'(depth_d);
  assign res.balanced  = verdict == bbc_pkg::VERDICT_OK;
  assign res.verdict   = verdict;
  assign res.open_left = (depth_ext > SatW'(255)) ? 8'hFF : depth_ext[bbc_pkg::OpenLeftW-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_addr] <= open_k;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      err_q     <= bbc_pkg::VERDICT_OK;
      sel_mem_q <= 1'b0;
    end else if (last_acc) begin
      depth_q   <= '0;
      err_q     <= bbc_pkg::VERDICT_OK;
      sel_mem_q <= 1'b0;
    end else begin
      depth_q   <= depth_d;
      err_q     <= err_d;
      sel_mem_q <= pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= last_acc;
      end
    end else if (last_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end else if (last_acc) begin
      skid_data_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.balanced  = out_data_q.balanced;
  assign out_o.verdict   = out_data_q.verdict;
  assign out_o.open_left = out_data_q.open_left;

endmodule

[tb/tb_bracket_balance_checker_core.sv]
`timescale 1ns / 1ps

module tb_bracket_balance_checker_core;

  localparam int unsigned Depth      = bbc_pkg::StackDepthDefault;
  localparam int unsigned ItemTarget = 1070;
  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    logic [bbc_pkg::ChW-1:0] ch;
    logic                    is_last;
  } char_t;

  typedef struct packed {
    logic                          balanced;
    bbc_pkg::verdict_e             verdict;
    logic [bbc_pkg::OpenLeftW-1:0] open_left;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  bbc_in_if  in_bus ();
  bbc_out_if out_bus ();

  bracket_balance_checker_core #(
    .STACK_DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  char_t                   char_queue[$];
  verdict_t                verdict_queue[$];
  logic [bbc_pkg::ChW-1:0] expr_buf[$];

  logic [bbc_pkg::KindW-1:0] open_stack[Depth];
  int unsigned               open_count;
  bbc_pkg::verdict_e         first_error = bbc_pkg::VERDICT_OK;

  int unsigned n_chars;
  int unsigned n_total;
  int unsigned n_verdicts;
  int unsigned n_bad;
  int unsigned verdict_tally[5];
  int          in_gap;
  int          out_stall;
  int          in_calm;
  int          out_calm;
  int          quiet;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [bbc_pkg::ChW-1:0] open_char(input logic [bbc_pkg::KindW-1:0] k);
    case (k)
      bbc_pkg::KindRound: return bbc_pkg::ChOpenRound;
      bbc_pkg::KindCurly: return bbc_pkg::ChOpenCurly;
      default:            return bbc_pkg::ChOpenSquare;
    endcase
  endfunction

  function automatic logic [bbc_pkg::ChW-1:0] close_char(input logic [bbc_pkg::KindW-1:0] k);
    case (k)
      bbc_pkg::KindRound: return bbc_pkg::ChCloseRound;
      bbc_pkg::KindCurly: return bbc_pkg::ChCloseCurly;
      default:            return bbc_pkg::ChCloseSquare;
    endcase
  endfunction

  function automatic logic [bbc_pkg::ChW-1:0] bracket_char();
    logic [bbc_pkg::KindW-1:0] k;
    k = bbc_pkg::KindW'($urandom_range(bbc_pkg::KindRound, bbc_pkg::KindSquare));
    return $urandom_range(0, 1) ? open_char(k) : close_char(k);
  endfunction

  function automatic logic [bbc_pkg::ChW-1:0] plain_char();
    logic [bbc_pkg::ChW-1:0] c;
    do begin
      c = bbc_pkg::ChW'($urandom_range(0, 255));
    end while (c inside {bbc_pkg::ChOpenRound, bbc_pkg::ChOpenCurly, bbc_pkg::ChOpenSquare,
                         bbc_pkg::ChCloseRound, bbc_pkg::ChCloseCurly,
                         bbc_pkg::ChCloseSquare});
    return c;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Tracks the stack for one accepted character and queues the verdict on the final one.
  function automatic void track_char(input logic [bbc_pkg::ChW-1:0] c, input logic last);
    logic [bbc_pkg::KindW-1:0] k;
    logic                      opener;
    verdict_t                  v;
    case (c)
      bbc_pkg::ChOpenRound, bbc_pkg::ChCloseRound:   k = bbc_pkg::KindRound;
      bbc_pkg::ChOpenCurly, bbc_pkg::ChCloseCurly:   k = bbc_pkg::KindCurly;
      bbc_pkg::ChOpenSquare, bbc_pkg::ChCloseSquare: k = bbc_pkg::KindSquare;
      default:                                       k = bbc_pkg::KindNone;
    endcase
    opener = c inside {bbc_pkg::ChOpenRound, bbc_pkg::ChOpenCurly, bbc_pkg::ChOpenSquare};
    if (first_error == bbc_pkg::VERDICT_OK && k != bbc_pkg::KindNone) begin
      if (opener) begin
        if (open_count == Depth) begin
          first_error = bbc_pkg::VERDICT_OVERFLOW;
        end else begin
          open_stack[open_count] = k;
          open_count++;
        end
      end else if (open_count == 0) begin
        first_error = bbc_pkg::VERDICT_UNMATCHED_CLOSE;
      end else if (open_stack[open_count-1] == k) begin
        open_count--;
      end else begin
        first_error = bbc_pkg::VERDICT_MISMATCH;
      end
    end
    if (last) begin
      v.verdict = (first_error != bbc_pkg::VERDICT_OK) ? first_error :
                  (open_count != 0) ? bbc_pkg::VERDICT_UNCLOSED : bbc_pkg::VERDICT_OK;
      v.balanced = (v.verdict == bbc_pkg::VERDICT_OK);
      v.open_left = (open_count >= (1 << bbc_pkg::OpenLeftW)) ? {bbc_pkg::OpenLeftW{1'b1}} :
                    open_count[bbc_pkg::OpenLeftW-1:0];
      verdict_queue.push_back(v);
      open_count = 0;
      first_error = bbc_pkg::VERDICT_OK;
    end
  endfunction

  task automatic send_expr();
    char_t c;
    if (expr_buf.size() == 0) begin
      expr_buf.push_back(plain_char());
    end
    foreach (expr_buf[i]) begin
      c.ch = expr_buf[i];
      c.is_last = (i == expr_buf.size() - 1);
      char_queue.push_back(c);
    end
    expr_buf.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expr_buf.push_back(s[i]);
    end
    send_expr();
  endtask

  task automatic gen_nested(input int unsigned len, input int unsigned noise_pct,
                            input bit close_all);
    logic [bbc_pkg::KindW-1:0] held[$];
    logic [bbc_pkg::KindW-1:0] k;
    repeat (len) begin
      if ($urandom_range(1, 100) <= noise_pct) begin
        expr_buf.push_back(plain_char());
      end else if (held.size() == 0 || (held.size() < Depth && $urandom_range(0, 1))) begin
        k = bbc_pkg::KindW'($urandom_range(bbc_pkg::KindRound, bbc_pkg::KindSquare));
        held.push_back(k);
        expr_buf.push_back(open_char(k));
      end else begin
        expr_buf.push_back(close_char(held.pop_back()));
      end
    end
    while (close_all && held.size() != 0) begin
      expr_buf.push_back(close_char(held.pop_back()));
    end
  endtask

  task automatic gen_deep(input int unsigned opens, input bit close_all);
    logic [bbc_pkg::KindW-1:0] held[$];
    logic [bbc_pkg::KindW-1:0] k;
    repeat (opens) begin
      if ($urandom_range(0, 9) == 0) begin
        expr_buf.push_back(plain_char());
      end
      k = bbc_pkg::KindW'($urandom_range(bbc_pkg::KindRound, bbc_pkg::KindSquare));
      held.push_back(k);
      expr_buf.push_back(open_char(k));
    end
    while (close_all && held.size() != 0) begin
      expr_buf.push_back(close_char(held.pop_back()));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    char_t c;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.ch <= '0;
      in_bus.is_last <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        track_char(in_bus.ch, in_bus.is_last);
        n_chars++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (char_queue.size() != 0) begin
          c = char_queue.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.ch <= c.ch;
          in_bus.is_last <= c.is_last;
          in_gap <= draw_wait(in_calm);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    int       w;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      n_verdicts++;
      if (verdict_queue.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("unexpected verdict transfer: balanced %0b verdict %0d open_left %0d",
                   out_bus.balanced, out_bus.verdict, out_bus.open_left);
        end
      end else begin
        want = verdict_queue.pop_front();
        verdict_tally[want.verdict]++;
        if (out_bus.balanced !== want.balanced || out_bus.verdict !== want.verdict ||
            out_bus.open_left !== want.open_left) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("verdict %0d: expected balanced %0b verdict %0d open_left %0d, got %0b %0d %0d",
                     n_verdicts, want.balanced, want.verdict, want.open_left,
                     out_bus.balanced, out_bus.verdict, out_bus.open_left);
          end
        end
      end
      w = draw_wait(out_calm);
      out_bus.ready <= (w == 0);
      out_stall <= (w == 0) ? 0 : w - 1;
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned pick;
    int unsigned pos;
    rst_ni = 1'b0;

    expr_buf.push_back(8'h00);
    send_expr();
    expr_buf.push_back(bbc_pkg::ChOpenRound);
    expr_buf.push_back(8'hFF);
    expr_buf.push_back(bbc_pkg::ChCloseRound);
    send_expr();
    send_text("{[]}");
    send_text(")");
    send_text("(])");
    send_text("[(");
    send_text("}(");
    send_text("{)");

    // A stack filled to the last entry, then one opening too many.
    gen_deep(Depth, 1'b0);
    send_expr();
    gen_deep(Depth + 1, 1'b1);
    send_expr();

    while (char_queue.size() < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        gen_deep($urandom_range(Depth - 8, Depth), 1'($urandom_range(0, 1)));
      end else if (pick < 3) begin
        gen_deep($urandom_range(Depth + 1, Depth + 6), 1'($urandom_range(0, 1)));
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 8)) begin
          expr_buf.push_back($urandom_range(0, 1) ? bracket_char() :
                             bbc_pkg::ChW'($urandom_range(0, 255)));
        end
      end else begin
        gen_nested($urandom_range(1, 16), 20, $urandom_range(0, 9) != 0);
        if (expr_buf.size() != 0 && $urandom_range(0, 6) == 0) begin
          pos = $urandom_range(0, expr_buf.size() - 1);
          expr_buf[pos] = bracket_char();
        end
      end
      send_expr();
    end
    n_total = char_queue.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_chars != n_total) @(posedge clk_i);
    while (verdict_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d characters; %0d verdicts: ok %0d, unmatched close %0d, mismatch %0d,",
             n_chars, n_verdicts, verdict_tally[bbc_pkg::VERDICT_OK],
             verdict_tally[bbc_pkg::VERDICT_UNMATCHED_CLOSE],
             verdict_tally[bbc_pkg::VERDICT_MISMATCH]);
    $display("unclosed %0d, overflow %0d; %0d mismatches.",
             verdict_tally[bbc_pkg::VERDICT_UNCLOSED], verdict_tally[bbc_pkg::VERDICT_OVERFLOW],
             n_bad);
    if (n_bad == 0 && verdict_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/bbc_pkg.sv
src/bbc_if.sv
src/bracket_balance_checker_core.sv
tb/tb_bracket_balance_checker_core.sv
